// ----- rtl/core/gbpg_pkg.sv -----
// Shared types and constants of the gradient bar pattern generator.
package gbpg_pkg;

  // Default limits handed to the top level parameters
  localparam int GBPG_MAX_WIDTH  = 4096;
  localparam int GBPG_MAX_HEIGHT = 4096;
  localparam int GBPG_MAX_BARS   = 256;

  // Fixed field widths
  localparam int CFG_DIM_W   = 13;
  localparam int CFG_BARS_W  = 9;
  localparam int COLOR_W     = 24;
  localparam int CFG_DATA_W  = 24;
  localparam int CFG_IDX_W   = 3;
  localparam int COMP_W      = 8;
  localparam int NUM_CHAN    = 3;
  localparam int PIX_COORD_W = 12;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_BAR_COUNT    = 3'd2,
    REG_START_COLOR  = 3'd3,
    REG_END_COLOR    = 3'd4
  } cfg_reg_e;

  localparam logic [CFG_DIM_W-1:0]  FRAME_WIDTH_RST  = 13'd640;
  localparam logic [CFG_DIM_W-1:0]  FRAME_HEIGHT_RST = 13'd480;
  localparam logic [CFG_BARS_W-1:0] BAR_COUNT_RST    = 9'd10;
  localparam logic [COLOR_W-1:0]    START_COLOR_RST  = 24'hFF0000;
  localparam logic [COLOR_W-1:0]    END_COLOR_RST    = 24'h0000FF;

  typedef struct packed {
    logic restart;
  } gbpg_req_t;

  typedef struct packed {
    logic [COMP_W-1:0]      comp_first;
    logic [COMP_W-1:0]      comp_second;
    logic [COMP_W-1:0]      comp_third;
    logic [PIX_COORD_W-1:0] pixel_column;
    logic [PIX_COORD_W-1:0] pixel_row;
    logic                   line_end;
    logic                   frame_end;
  } gbpg_pix_t;

  // Status of the setup sequencer as seen by the top level
  typedef struct packed {
    logic busy;      // divisions or table fill in progress
    logic pos_load;  // raster position results are valid this cycle
    logic tbl_we;    // color table write this cycle
  } setup_ctl_t;

endpackage

// ----- rtl/core/gbpg_stream_if.sv -----
// Valid/ready stream channel carrying one payload per request.
interface gbpg_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/gbpg_divider.sv -----
// Serial restoring divider, one quotient bit per cycle.
module gbpg_divider #(
  parameter int DIV_W = 13
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] dividend_i,
  input  logic [DIV_W-1:0] divisor_i,
  output logic [DIV_W-1:0] quot_o,
  output logic [DIV_W-1:0] rem_o,
  output logic             done_o
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [CNT_W-1:0] cnt_q;
  logic             run_q;
  logic             done_q;
  logic [DIV_W-1:0] quot_q;
  logic [DIV_W-1:0] rem_q;
  logic [DIV_W-1:0] dvs_q;
  logic [DIV_W:0]   shifted;
  logic [DIV_W:0]   diff;

  assign shifted = {rem_q, quot_q[DIV_W-1]};
  assign diff    = shifted - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CNT_W'(DIV_W);
        run_q <= 1'b1;
      end else if (run_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvs_q  <= divisor_i;
      quot_q <= dividend_i;
      rem_q  <= '0;
    end else if (run_q) begin
      quot_q <= {quot_q[DIV_W-2:0], ~diff[DIV_W]};
      rem_q  <= diff[DIV_W] ? shifted[DIV_W-1:0] : diff[DIV_W-1:0];
    end
  end

  assign quot_o = quot_q;
  assign rem_o  = rem_q;
  assign done_o = done_q;

endmodule

// ----- rtl/core/gbpg_setup.sv -----
// Setup sequencer: bar width, raster position and per-bar color table fill.
module gbpg_setup import gbpg_pkg::*; #(
  parameter int MAX_WIDTH = GBPG_MAX_WIDTH,
  parameter int MAX_BARS  = GBPG_MAX_BARS,
  parameter int DIV_W     = 13
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [$clog2(MAX_WIDTH):0]     w_eff_i,
  input  logic [$clog2(MAX_BARS+1)-1:0]  bars_eff_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]   col_eff_i,
  input  logic [COLOR_W-1:0]             start_color_i,
  input  logic [COLOR_W-1:0]             end_color_i,
  output setup_ctl_t                     ctl_o,
  output logic [$clog2(MAX_WIDTH)-1:0]   bar_width_o,
  output logic [$clog2(MAX_WIDTH)-1:0]   pos_index_o,
  output logic [$clog2(MAX_WIDTH)-1:0]   pos_offset_o,
  output logic [$clog2(MAX_WIDTH)-1:0]   tbl_addr_o,
  output logic [COLOR_W-1:0]             tbl_data_o
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int WW     = COL_W + 1;
  localparam int BAR_W  = $clog2(MAX_BARS);
  localparam logic [1:0] LAST_CHAN = 2'(NUM_CHAN - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BW,
    ST_POS,
    ST_STEP,
    ST_FILL
  } state_e;

  state_e            state_q;
  logic              go_q;
  logic              pos_load_q;
  logic [1:0]        chan_q;
  logic [COL_W-1:0]  bw_q;
  logic [COL_W-1:0]  idx_q;
  logic [COL_W-1:0]  off_q;
  logic [COL_W-1:0]  fill_q;
  logic [COMP_W-1:0] acc_q   [NUM_CHAN];
  logic [BAR_W-1:0]  rem_q   [NUM_CHAN];
  logic [COMP_W-1:0] qstep_q [NUM_CHAN];
  logic [BAR_W-1:0]  rstep_q [NUM_CHAN];

  logic [COMP_W-1:0] s_b   [NUM_CHAN];
  logic [COMP_W-1:0] e_b   [NUM_CHAN];
  logic              sgn   [NUM_CHAN];
  logic [COMP_W-1:0] mag   [NUM_CHAN];
  logic [BAR_W:0]    rsum  [NUM_CHAN];
  logic              wrap  [NUM_CHAN];
  logic [BAR_W-1:0]  rem_d [NUM_CHAN];
  logic [COMP_W-1:0] acc_d [NUM_CHAN];
  logic [COMP_W-1:0] comp  [NUM_CHAN];
  logic [BAR_W-1:0]  bm1;

  logic [DIV_W-1:0]  div_dividend;
  logic [DIV_W-1:0]  div_divisor;
  logic [DIV_W-1:0]  div_quot;
  logic [DIV_W-1:0]  div_rem;
  logic              div_done;
  logic              div_take;

  assign bm1 = BAR_W'(bars_eff_i - 1'b1);

  // Gradient per channel: quotient mod 256 and remainder of idx*|d|/(bars-1),
  // advanced one bar per fill cycle.
  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      s_b[c]   = start_color_i[COMP_W*(NUM_CHAN-1-c) +: COMP_W];
      e_b[c]   = end_color_i[COMP_W*(NUM_CHAN-1-c) +: COMP_W];
      sgn[c]   = e_b[c] < s_b[c];
      mag[c]   = sgn[c] ? s_b[c] - e_b[c] : e_b[c] - s_b[c];
      rsum[c]  = {1'b0, rem_q[c]} + {1'b0, rstep_q[c]};
      wrap[c]  = rsum[c] >= {1'b0, bm1};
      rem_d[c] = wrap[c] ? rsum[c][BAR_W-1:0] - bm1 : rsum[c][BAR_W-1:0];
      acc_d[c] = acc_q[c] + qstep_q[c] + COMP_W'(wrap[c]);
      comp[c]  = sgn[c] ? s_b[c] - acc_q[c] : s_b[c] + acc_q[c];
    end
  end

  always_comb begin
    unique case (state_q)
      ST_BW: begin
        div_dividend = DIV_W'(w_eff_i);
        div_divisor  = DIV_W'(bars_eff_i);
      end
      ST_POS: begin
        div_dividend = DIV_W'(col_eff_i);
        div_divisor  = DIV_W'(bw_q);
      end
      ST_STEP: begin
        div_dividend = DIV_W'(mag[chan_q]);
        div_divisor  = DIV_W'(bm1);
      end
      default: begin
        div_dividend = '0;
        div_divisor  = DIV_W'(1);
      end
    endcase
  end

  gbpg_divider #(
    .DIV_W(DIV_W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (go_q),
    .dividend_i(div_dividend),
    .divisor_i (div_divisor),
    .quot_o    (div_quot),
    .rem_o     (div_rem),
    .done_o    (div_done)
  );

  // a done left over from an aborted division is ignored while a new one starts
  assign div_take = div_done && !go_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_BW;
      go_q       <= 1'b1;
      pos_load_q <= 1'b0;
      chan_q     <= '0;
      bw_q       <= COL_W'(1);
      idx_q      <= '0;
      off_q      <= '0;
      fill_q     <= '0;
      for (int c = 0; c < NUM_CHAN; c++) begin
        acc_q[c]   <= '0;
        rem_q[c]   <= '0;
        qstep_q[c] <= '0;
        rstep_q[c] <= '0;
      end
    end else begin
      go_q       <= 1'b0;
      pos_load_q <= 1'b0;
      if (start_i) begin
        state_q <= ST_BW;
        go_q    <= 1'b1;
      end else begin
        unique case (state_q)
          ST_IDLE: begin
            state_q <= ST_IDLE;
          end
          ST_BW: begin
            if (div_take) begin
              bw_q    <= (div_quot == '0) ? COL_W'(1) : div_quot[COL_W-1:0];
              go_q    <= 1'b1;
              state_q <= ST_POS;
            end
          end
          ST_POS: begin
            if (div_take) begin
              idx_q      <= div_quot[COL_W-1:0];
              off_q      <= div_rem[COL_W-1:0];
              pos_load_q <= 1'b1;
              chan_q     <= '0;
              go_q       <= 1'b1;
              state_q    <= ST_STEP;
            end
          end
          ST_STEP: begin
            if (div_take) begin
              qstep_q[chan_q] <= div_quot[COMP_W-1:0];
              rstep_q[chan_q] <= div_rem[BAR_W-1:0];
              if (chan_q == LAST_CHAN) begin
                fill_q <= '0;
                for (int c = 0; c < NUM_CHAN; c++) begin
                  acc_q[c] <= '0;
                  rem_q[c] <= '0;
                end
                state_q <= ST_FILL;
              end else begin
                chan_q <= chan_q + 1'b1;
                go_q   <= 1'b1;
              end
            end
          end
          ST_FILL: begin
            for (int c = 0; c < NUM_CHAN; c++) begin
              acc_q[c] <= acc_d[c];
              rem_q[c] <= rem_d[c];
            end
            fill_q <= fill_q + 1'b1;
            if ({1'b0, fill_q} == w_eff_i - WW'(1)) begin
              state_q <= ST_IDLE;
            end
          end
          default: begin
            state_q <= ST_IDLE;
          end
        endcase
      end
    end
  end

  assign ctl_o.busy     = (state_q != ST_IDLE);
  assign ctl_o.pos_load = pos_load_q;
  assign ctl_o.tbl_we   = (state_q == ST_FILL);
  assign bar_width_o    = bw_q;
  assign pos_index_o    = idx_q;
  assign pos_offset_o   = off_q;
  assign tbl_addr_o     = fill_q;
  assign tbl_data_o     = {comp[0], comp[1], comp[2]};

endmodule

// ----- rtl/core/gradient_bar_pattern_generator_core.sv -----
// Gradient bar test pattern generator, top level.
//
//   channel   dir  handshake            payload
//   req_i     in   valid / ready        gbpg_req_t  (restart)
//   pix_o     out  valid / ready        gbpg_pix_t  (components, position, flags)
//   cfg       in   cfg_we_i, no stall   cfg_idx_i, cfg_wdata_i
//
// After setup, one pixel per cycle: a request is taken whenever the output
// register is empty or being drained, and its pixel shows in the next cycle.
// Setup runs after reset and after every config write: five serial divisions,
// then a fill of the color table column by column (640 entries at reset
// values). No request is taken during setup. A stalled pixel holds in the
// output register.
module gradient_bar_pattern_generator_core import gbpg_pkg::*; #(
  parameter int MAX_WIDTH  = GBPG_MAX_WIDTH,
  parameter int MAX_HEIGHT = GBPG_MAX_HEIGHT,
  parameter int MAX_BARS   = GBPG_MAX_BARS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  gbpg_stream_if.sink          req_i,
  gbpg_stream_if.source        pix_o
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int WW     = COL_W + 1;
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int HW     = ROW_W + 1;
  localparam int BAR_CW = $clog2(MAX_BARS + 1);
  localparam int DIV_A  = (WW > BAR_CW) ? WW : BAR_CW;
  localparam int DIV_W  = (DIV_A > COMP_W) ? DIV_A : COMP_W;

  // Configuration registers
  logic [CFG_DIM_W-1:0]  frame_width_q;
  logic [CFG_DIM_W-1:0]  frame_height_q;
  logic [CFG_BARS_W-1:0] bar_count_q;
  logic [COLOR_W-1:0]    start_color_q;
  logic [COLOR_W-1:0]    end_color_q;
  logic                  cfg_wr_q;   // setup kicks off the cycle after a write

  // Raster state: next position and its place within the bars
  logic [COL_W-1:0] col_q;
  logic [ROW_W-1:0] row_q;
  logic [COL_W-1:0] idx_q;
  logic [COL_W-1:0] off_q;

  // Output register; the color comes straight from the table read port
  logic             out_valid_q;
  logic [COL_W-1:0] out_col_q;
  logic [ROW_W-1:0] out_row_q;
  logic             out_le_q;
  logic             out_fe_q;
  logic [COLOR_W-1:0] rd_q;

  // Per-bar color table, indexed by bar number
  logic [COLOR_W-1:0] color_mem [MAX_WIDTH];

  // Effective (clamped) settings
  logic [WW-1:0]     w_eff;
  logic [HW-1:0]     h_eff;
  logic [BAR_CW-1:0] bars_eff;
  logic [WW-1:0]     w_m1;
  logic [HW-1:0]     h_m1;
  logic [COL_W-1:0]  col_eff;
  logic [ROW_W-1:0]  row_eff;

  // Current request
  logic             req_acc;
  logic             restart;
  logic [COL_W-1:0] col_cur;
  logic [ROW_W-1:0] row_cur;
  logic [COL_W-1:0] idx_cur;
  logic [COL_W-1:0] off_cur;
  logic             le;
  logic             fe;
  logic             bar_end;

  // Setup sequencer
  setup_ctl_t         setup_ctl;
  logic [COL_W-1:0]   bar_width;
  logic [COL_W-1:0]   pos_index;
  logic [COL_W-1:0]   pos_offset;
  logic [COL_W-1:0]   tbl_addr;
  logic [COLOR_W-1:0] tbl_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FRAME_WIDTH_RST;
      frame_height_q <= FRAME_HEIGHT_RST;
      bar_count_q    <= BAR_COUNT_RST;
      start_color_q  <= START_COLOR_RST;
      end_color_q    <= END_COLOR_RST;
      cfg_wr_q       <= 1'b0;
    end else begin
      cfg_wr_q <= cfg_we_i;
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_idx_i))
          REG_FRAME_WIDTH:  frame_width_q  <= cfg_wdata_i[CFG_DIM_W-1:0];
          REG_FRAME_HEIGHT: frame_height_q <= cfg_wdata_i[CFG_DIM_W-1:0];
          REG_BAR_COUNT:    bar_count_q    <= cfg_wdata_i[CFG_BARS_W-1:0];
          REG_START_COLOR:  start_color_q  <= cfg_wdata_i[COLOR_W-1:0];
          REG_END_COLOR:    end_color_q    <= cfg_wdata_i[COLOR_W-1:0];
          default: ;  // unused index, setup reruns harmlessly
        endcase
      end
    end
  end

  // Clamp the registers into the supported range
  always_comb begin
    if (frame_width_q == '0) begin
      w_eff = WW'(1);
    end else if (32'(frame_width_q) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(frame_width_q);
    end

    if (frame_height_q == '0) begin
      h_eff = HW'(1);
    end else if (32'(frame_height_q) > 32'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(frame_height_q);
    end

    if (32'(bar_count_q) < 32'd2) begin
      bars_eff = BAR_CW'(2);
    end else if (32'(bar_count_q) > 32'(MAX_BARS)) begin
      bars_eff = BAR_CW'(MAX_BARS);
    end else begin
      bars_eff = BAR_CW'(bar_count_q);
    end

    w_m1 = w_eff - WW'(1);
    h_m1 = h_eff - HW'(1);

    // a position past a shrunk frame sits on its last column / row
    col_eff = ({1'b0, col_q} > w_m1) ? w_m1[COL_W-1:0] : col_q;
    row_eff = ({1'b0, row_q} > h_m1) ? h_m1[ROW_W-1:0] : row_q;
  end

  gbpg_setup #(
    .MAX_WIDTH(MAX_WIDTH),
    .MAX_BARS (MAX_BARS),
    .DIV_W    (DIV_W)
  ) u_setup (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (cfg_wr_q),
    .w_eff_i      (w_eff),
    .bars_eff_i   (bars_eff),
    .col_eff_i    (col_eff),
    .start_color_i(start_color_q),
    .end_color_i  (end_color_q),
    .ctl_o        (setup_ctl),
    .bar_width_o  (bar_width),
    .pos_index_o  (pos_index),
    .pos_offset_o (pos_offset),
    .tbl_addr_o   (tbl_addr),
    .tbl_data_o   (tbl_data)
  );

  // Requests wait while setup runs, a write is about to restart it, or the output register is full and not drained
  assign req_i.ready = !setup_ctl.busy && !cfg_wr_q && (!out_valid_q || pix_o.ready);
  assign req_acc     = req_i.valid && req_i.ready;

  always_comb begin
    restart = req_i.data.restart;
    col_cur = restart ? '0 : col_q;
    row_cur = restart ? '0 : row_q;
    idx_cur = restart ? '0 : idx_q;
    off_cur = restart ? '0 : off_q;
    le      = ({1'b0, col_cur} == w_m1);
    fe      = le && ({1'b0, row_cur} == h_m1);
    bar_end = (off_cur == bar_width - COL_W'(1));
  end

  // Raster counters: bar index advances when the offset reaches the bar width minus one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      idx_q       <= '0;
      off_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (setup_ctl.pos_load) begin
        col_q <= col_eff;
        row_q <= row_eff;
        idx_q <= pos_index;
        off_q <= pos_offset;
      end else if (req_acc) begin
        if (le) begin
          col_q <= '0;
          idx_q <= '0;
          off_q <= '0;
          row_q <= fe ? '0 : row_cur + 1'b1;
        end else begin
          col_q <= col_cur + 1'b1;
          row_q <= row_cur;
          if (bar_end) begin
            off_q <= '0;
            idx_q <= idx_cur + 1'b1;
          end else begin
            off_q <= off_cur + 1'b1;
            idx_q <= idx_cur;
          end
        end
      end

      if (req_acc) begin
        out_valid_q <= 1'b1;
      end else if (pix_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Table port: fill writes during setup, pixel reads only outside it
  always_ff @(posedge clk_i) begin
    if (setup_ctl.tbl_we) begin
      color_mem[tbl_addr] <= tbl_data;
    end
    if (req_acc) begin
      rd_q      <= color_mem[idx_cur];
      out_col_q <= col_cur;
      out_row_q <= row_cur;
      out_le_q  <= le;
      out_fe_q  <= fe;
    end
  end

  assign pix_o.valid = out_valid_q;
  assign pix_o.data  = '{
    comp_first:   rd_q[3*COMP_W-1:2*COMP_W],
    comp_second:  rd_q[2*COMP_W-1:COMP_W],
    comp_third:   rd_q[COMP_W-1:0],
    pixel_column: PIX_COORD_W'(out_col_q),
    pixel_row:    PIX_COORD_W'(out_row_q),
    line_end:     out_le_q,
    frame_end:    out_fe_q
  };

`ifndef SYNTHESIS
  // an accepted request always lands in the output register
  a_req_to_pix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc |=> pix_o.valid)
    else $error("accepted request did not produce a pixel");

  // once setup settles, the column is inside the current frame
  a_col_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!setup_ctl.busy && !cfg_wr_q) |-> ({1'b0, col_q} <= w_m1))
    else $error("column counter beyond frame width");

  // once setup settles, the offset lies within the current bar
  a_off_in_bar: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!setup_ctl.busy && !cfg_wr_q) |-> (off_q < bar_width))
    else $error("bar offset beyond bar width");
`endif

endmodule
